FILE: rtl/mtsd_pkg.sv
package mtsd_pkg;

	// default sizes of the table
	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COUNT_BITS_DEF  = 16;

	// fixed field widths
	localparam int SYM_BITS   = 8;
	localparam int TALLY_BITS = 16;
	localparam int TDATA_BITS = 24;   // symbol_out + tally, three whole bytes

	// command codes carried on s_tuser
	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_DUMP   = 1'b1;

	// control broadcast to every table cell
	typedef struct packed {
		logic rec;      // apply a record of the latched symbol
		logic rotate;   // take the contents of the right neighbor
		logic hit_any;  // some occupied cell holds the symbol
	} tbl_ctl_t;

	// control broadcast to every sort cell
	typedef struct packed {
		logic insert;   // systolic insertion step
		logic shift;    // shift held entries toward cell zero
	} sort_ctl_t;

endpackage

FILE: rtl/mtsd_tbl_cell.sv
module mtsd_tbl_cell
	import mtsd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  tbl_ctl_t              ctl,
	input  logic [SYM_BITS-1:0]   sym,
	input  logic                  occ,       // this cell holds an entry
	input  logic                  is_next,   // this cell is the next free entry
	input  logic [SYM_BITS-1:0]   nb_key,
	input  logic [COUNT_BITS-1:0] nb_cnt,
	output logic [SYM_BITS-1:0]   key,
	output logic [COUNT_BITS-1:0] cnt,
	output logic                  match
);

	logic [SYM_BITS-1:0]   key_q;
	logic [COUNT_BITS-1:0] cnt_q;

	assign key   = key_q;
	assign cnt   = cnt_q;
	assign match = occ && (key_q == sym);

	// rotate during a dump, else count a hit or claim a free entry
	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			key_q <= nb_key;
			cnt_q <= nb_cnt;
		end else if (ctl.rec) begin
			if (match) begin
				if (cnt_q != {COUNT_BITS{1'b1}}) begin
					cnt_q <= cnt_q + COUNT_BITS'(1);
				end
			end else if (is_next && !ctl.hit_any) begin
				key_q <= sym;
				cnt_q <= COUNT_BITS'(1);
			end
		end
	end

endmodule

FILE: rtl/mtsd_sort_cell.sv
module mtsd_sort_cell
	import mtsd_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sort_ctl_t             ctl,
	// entry arriving from the left
	input  logic                  in_valid,
	input  logic [SYM_BITS-1:0]   in_key,
	input  logic [COUNT_BITS-1:0] in_cnt,
	// held entry of the right neighbor
	input  logic                  nb_valid,
	input  logic [SYM_BITS-1:0]   nb_key,
	input  logic [COUNT_BITS-1:0] nb_cnt,
	// held entry
	output logic                  hold_valid,
	output logic [SYM_BITS-1:0]   hold_key,
	output logic [COUNT_BITS-1:0] hold_cnt,
	// entry passed on to the right
	output logic                  fwd_valid,
	output logic [SYM_BITS-1:0]   fwd_key,
	output logic [COUNT_BITS-1:0] fwd_cnt
);

	logic                  hv_q;
	logic [SYM_BITS-1:0]   hk_q;
	logic [COUNT_BITS-1:0] hc_q;
	logic                  fv_q;
	logic [SYM_BITS-1:0]   fk_q;
	logic [COUNT_BITS-1:0] fc_q;

	assign hold_valid = hv_q;
	assign hold_key   = hk_q;
	assign hold_cnt   = hc_q;
	assign fwd_valid  = fv_q;
	assign fwd_key    = fk_q;
	assign fwd_cnt    = fc_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			fv_q <= 1'b0;
		end else if (ctl.shift) begin
			hv_q <= nb_valid;
			fv_q <= 1'b0;
		end else if (ctl.insert && in_valid) begin
			hv_q <= 1'b1;
			fv_q <= hv_q;
		end else begin
			fv_q <= 1'b0;
		end
	end

	// payload: keep the larger count, equal counts keep the earlier entry
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			hk_q <= nb_key;
			hc_q <= nb_cnt;
		end else if (ctl.insert && in_valid) begin
			if (!hv_q) begin
				hk_q <= in_key;
				hc_q <= in_cnt;
			end else if (in_cnt > hc_q) begin
				hk_q <= in_key;
				hc_q <= in_cnt;
				fk_q <= hk_q;
				fc_q <= hc_q;
			end else begin
				fk_q <= in_key;
				fc_q <= in_cnt;
			end
		end
	end

endmodule

FILE: rtl/miss_tally_table_sorted_dump_unit.sv
// Channel   Dir  Signals                          Content
// s_*       in   tvalid tready tdata[7:0] tuser   symbol; tuser = command
// m_*       out  tvalid tready tdata[23:0] tlast  symbol_out, tally; tlast = last
//                tuser                            tuser = empty_res
//
// A record: accept, then the REC state, in which every table cell compares and
// updates in parallel.
// A dump: the table chain rotates once through the sort chain, the sort chain
// settles, then shifts out one entry per cycle while the output is not stalled.
// An empty dump gives a single result marked empty and last.
// m_tready low holds the readout shift.
// Reset clears the entry count and the sort chain; no clearing pass is needed.
module miss_tally_table_sorted_dump_unit
	import mtsd_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SYM_BITS-1:0]   s_tdata,   // [7:0] symbol
	input  logic                  s_tuser,   // [0] command
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata,   // [7:0] symbol_out, [23:8] tally
	output logic                  m_tlast,   // last
	output logic                  m_tuser    // [0] empty_res
);

	localparam int UW  = $clog2(TABLE_DEPTH + 1);
	// sort key: count on top, inverted entry index below, so ties go to the earlier entry
	localparam int SKW = COUNT_BITS + UW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_REC    = 3'd1;
	localparam logic [2:0] ST_FEED   = 3'd2;
	localparam logic [2:0] ST_SETTLE = 3'd3;
	localparam logic [2:0] ST_OUT    = 3'd4;
	localparam logic [2:0] ST_EMPTY  = 3'd5;

	logic [2:0]          state_q;
	logic [SYM_BITS-1:0] sym_q;
	logic [UW-1:0]       used_q;
	logic [UW-1:0]       step_q;
	logic [UW-1:0]       outn_q;

	logic                  out_valid_q;
	logic [SYM_BITS-1:0]   out_sym_q;
	logic [TALLY_BITS-1:0] out_tally_q;
	logic                  out_last_q;
	logic                  out_empty_q;

	tbl_ctl_t  tctl;
	sort_ctl_t sctl;

	logic [SYM_BITS-1:0]   tk [TABLE_DEPTH];
	logic [COUNT_BITS-1:0] tc [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tmatch;

	logic                  sv [TABLE_DEPTH];
	logic [SYM_BITS-1:0]   sk [TABLE_DEPTH];
	logic [SKW-1:0]        sc [TABLE_DEPTH];
	logic                  fv [TABLE_DEPTH];
	logic [SYM_BITS-1:0]   fk [TABLE_DEPTH];
	logic [SKW-1:0]        fc [TABLE_DEPTH];

	logic                  s_acc;
	logic                  out_free;
	logic                  feed_valid;
	logic                  step_end;
	logic [COUNT_BITS-1:0] head_cnt;
	logic [TALLY_BITS-1:0] head_tally;

	assign s_tready   = (state_q == ST_IDLE);
	assign s_acc      = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign feed_valid = (step_q < used_q);
	assign step_end   = (step_q == UW'(TABLE_DEPTH - 1));

	// cell control
	always_comb begin
		tctl.rec     = (state_q == ST_REC);
		tctl.rotate  = (state_q == ST_FEED);
		tctl.hit_any = |tmatch;
		sctl.insert  = (state_q == ST_FEED) || (state_q == ST_SETTLE);
		sctl.shift   = (state_q == ST_OUT) && out_free;
	end

	// table chain, in first-seen order
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_tbl
		mtsd_tbl_cell #(
			.COUNT_BITS(COUNT_BITS)
		) u_cell (
			.clk    (clk),
			.ctl    (tctl),
			.sym    (sym_q),
			.occ    (UW'(i) < used_q),
			.is_next(UW'(i) == used_q),
			.nb_key (tk[(i + 1) % TABLE_DEPTH]),
			.nb_cnt (tc[(i + 1) % TABLE_DEPTH]),
			.key    (tk[i]),
			.cnt    (tc[i]),
			.match  (tmatch[i])
		);
	end

	// sort chain, largest count at cell zero
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_sort
		logic                  iv;
		logic [SYM_BITS-1:0]   ik;
		logic [SKW-1:0]        ic;
		logic                  nv;
		logic [SYM_BITS-1:0]   nk;
		logic [SKW-1:0]        nc;

		if (i == 0) begin : g_first
			assign iv = feed_valid && (state_q == ST_FEED);
			assign ik = tk[0];
			assign ic = {tc[0], ~step_q};
		end else begin : g_mid
			assign iv = fv[i - 1];
			assign ik = fk[i - 1];
			assign ic = fc[i - 1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_end
			assign nv = 1'b0;
			assign nk = '0;
			assign nc = '0;
		end else begin : g_nb
			assign nv = sv[i + 1];
			assign nk = sk[i + 1];
			assign nc = sc[i + 1];
		end

		mtsd_sort_cell #(
			.COUNT_BITS(SKW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (sctl),
			.in_valid  (iv),
			.in_key    (ik),
			.in_cnt    (ic),
			.nb_valid  (nv),
			.nb_key    (nk),
			.nb_cnt    (nc),
			.hold_valid(sv[i]),
			.hold_key  (sk[i]),
			.hold_cnt  (sc[i]),
			.fwd_valid (fv[i]),
			.fwd_key   (fk[i]),
			.fwd_cnt   (fc[i])
		);
	end

	// count of the head entry
	assign head_cnt = sc[0][SKW-1:UW];

	// tally of the head entry, held at the field maximum
	if (COUNT_BITS > TALLY_BITS) begin : g_sat
		assign head_tally = (|head_cnt[COUNT_BITS-1:TALLY_BITS]) ? {TALLY_BITS{1'b1}}
		                                                         : head_cnt[TALLY_BITS-1:0];
	end else begin : g_ext
		assign head_tally = TALLY_BITS'(head_cnt);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			used_q  <= '0;
			step_q  <= '0;
			outn_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						step_q <= '0;
						if (s_tuser == CMD_RECORD) begin
							state_q <= ST_REC;
						end else if (used_q == '0) begin
							state_q <= ST_EMPTY;
						end else begin
							state_q <= ST_FEED;
						end
					end
				end
				ST_REC: begin
					if (!tctl.hit_any && (used_q != UW'(TABLE_DEPTH))) begin
						used_q <= used_q + UW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_FEED: begin
					step_q <= step_end ? '0 : step_q + UW'(1);
					if (step_end) begin
						state_q <= ST_SETTLE;
					end
				end
				ST_SETTLE: begin
					step_q <= step_end ? '0 : step_q + UW'(1);
					if (step_end) begin
						outn_q  <= '0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						outn_q <= outn_q + UW'(1);
						if ((outn_q + UW'(1)) == used_q) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// latch the symbol of a record
	always_ff @(posedge clk) begin
		if (s_acc) begin
			sym_q <= s_tdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free && ((state_q == ST_OUT) || (state_q == ST_EMPTY))) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && (state_q == ST_OUT)) begin
			out_sym_q   <= sk[0];
			out_tally_q <= head_tally;
			out_last_q  <= ((outn_q + UW'(1)) == used_q);
			out_empty_q <= 1'b0;
		end else if (out_free && (state_q == ST_EMPTY)) begin
			out_sym_q   <= '0;
			out_tally_q <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_tally_q, out_sym_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_empty_q;

endmodule

FILE: rtl/mtsd_checker.sv
module mtsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		                          && $stable(m_tuser))
		else $error("stalled result changed");

	// the empty marker is always the final result of its dump
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("empty result not marked last");

	// the empty marker carries no entry
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 24'd0))
		else $error("empty result carries data");

	// a real entry has been recorded at least once
	a_tally_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> (m_tdata[23:8] != 16'd0))
		else $error("entry with zero tally");

	// a dump in progress accepts no new item until its last result is out
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken during a dump");

endmodule

bind miss_tally_table_sorted_dump_unit mtsd_checker u_mtsd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tdata (s_tdata),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

FILE: sim/miss_tally_table_sorted_dump_unit_tb.sv
`timescale 1ns / 1ps

module miss_tally_table_sorted_dump_unit_tb;
	import mtsd_pkg::*;

	localparam int DEPTH      = TABLE_DEPTH_DEF;
	localparam int CNT_BITS   = COUNT_BITS_DEF;
	localparam int STALL_PCT  = 24;
	localparam int HANG_LIMIT = 4000;   // longest stretch with no transfer before the watchdog fires
	localparam int DRAIN_WAIT = 3 * DEPTH + 20;

	typedef struct {
		logic                  cmd;
		logic [SYM_BITS-1:0]   sym;
	} miss_item_t;

	typedef struct {
		logic [SYM_BITS-1:0]   sym;
		logic [TALLY_BITS-1:0] tally;
		logic                  last;
		logic                  empty;
	} dump_row_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SYM_BITS-1:0]   s_tdata  = '0;
	logic                  s_tuser  = CMD_RECORD;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [TDATA_BITS-1:0] m_tdata;
	logic                  m_tlast;
	logic                  m_tuser;

	miss_tally_table_sorted_dump_unit #(
		.TABLE_DEPTH(DEPTH),
		.COUNT_BITS (CNT_BITS)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// shadow copy of the tally table
	logic [SYM_BITS-1:0] shadow_key [DEPTH];
	logic [CNT_BITS-1:0] shadow_cnt [DEPTH];
	int                  shadow_used = 0;

	miss_item_t pending_items[$];
	dump_row_t  due_rows[$];
	miss_item_t next_item;

	int errors      = 0;
	int cyc         = 0;
	int idle_cycles = 0;
	int n_records   = 0;
	int n_dumps     = 0;
	int n_empty     = 0;
	int n_dropped   = 0;
	int n_sat_holds = 0;
	int n_rows      = 0;
	logic calm;

	// stretch with no idling on either side
	assign calm = (cyc >= 2000) && (cyc < 3500);

	// apply one accepted transfer to the shadow table, queue the rows it causes
	task automatic tally_apply(input logic cmd, input logic [SYM_BITS-1:0] sym);
		int        ord [DEPTH];
		int        j;
		bit        hit;
		dump_row_t row;
		hit = 1'b0;
		if (cmd == CMD_RECORD) begin
			n_records++;
			for (int i = 0; i < shadow_used; i++) begin
				if (!hit && shadow_key[i] == sym) begin
					hit = 1'b1;
					if (shadow_cnt[i] != '1)
						shadow_cnt[i] = shadow_cnt[i] + 1'b1;
					else
						n_sat_holds++;
				end
			end
			if (!hit) begin
				if (shadow_used < DEPTH) begin
					shadow_key[shadow_used] = sym;
					shadow_cnt[shadow_used] = 1;
					shadow_used++;
				end else begin
					n_dropped++;
				end
			end
		end else begin
			n_dumps++;
			if (shadow_used == 0) begin
				n_empty++;
				row.sym   = '0;
				row.tally = '0;
				row.last  = 1'b1;
				row.empty = 1'b1;
				due_rows.push_back(row);
			end else begin
				// stable insertion sort, highest count first, ties by first sighting
				for (int i = 0; i < shadow_used; i++) begin
					j = i;
					while (j > 0 && shadow_cnt[ord[j-1]] < shadow_cnt[i]) begin
						ord[j] = ord[j-1];
						j--;
					end
					ord[j] = i;
				end
				for (int i = 0; i < shadow_used; i++) begin
					row.sym   = shadow_key[ord[i]];
					row.tally = (64'(shadow_cnt[ord[i]]) > 64'hFFFF) ? 16'hFFFF
						: TALLY_BITS'(shadow_cnt[ord[i]]);
					row.last  = (i == shadow_used - 1);
					row.empty = 1'b0;
					due_rows.push_back(row);
				end
			end
		end
	endtask

	task automatic queue_item(input logic cmd, input logic [SYM_BITS-1:0] sym);
		miss_item_t it;
		it.cmd = cmd;
		it.sym = sym;
		pending_items.push_back(it);
	endtask

	// driver: feed the slave side from the pending queue
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= CMD_RECORD;
		end else begin
			if (s_tvalid && s_tready)
				tally_apply(s_tuser, s_tdata);
			if (!s_tvalid || s_tready) begin
				if (pending_items.size() > 0 &&
				    (calm || $urandom_range(0, 99) >= STALL_PCT)) begin
					next_item = pending_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= next_item.sym;
					s_tuser  <= next_item.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random backpressure, check every transfer on the master side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (due_rows.size() == 0) begin
					$error("unexpected result: symbol_out %0h tally %0d last %0b empty_res %0b",
						m_tdata[7:0], m_tdata[23:8], m_tlast, m_tuser);
					errors++;
				end else begin
					dump_row_t exp_row;
					exp_row = due_rows.pop_front();
					n_rows++;
					if (m_tdata[7:0] !== exp_row.sym) begin
						$error("symbol_out: expected %0h, got %0h", exp_row.sym, m_tdata[7:0]);
						errors++;
					end
					if (m_tdata[23:8] !== exp_row.tally) begin
						$error("tally: expected %0d, got %0d", exp_row.tally, m_tdata[23:8]);
						errors++;
					end
					if (m_tlast !== exp_row.last) begin
						$error("last: expected %0b, got %0b", exp_row.last, m_tlast);
						errors++;
					end
					if (m_tuser !== exp_row.empty) begin
						$error("empty_res: expected %0b, got %0b", exp_row.empty, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// watchdog: cycles without any transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			cyc++;
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= HANG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d rows outstanding",
					HANG_LIMIT, due_rows.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		// directed: empty dump, single entry, all-ones / all-zeros / alternating symbols, ties
		queue_item(CMD_DUMP,   8'h00);
		queue_item(CMD_RECORD, 8'h00);
		queue_item(CMD_DUMP,   8'hFF);
		queue_item(CMD_RECORD, 8'hFF);
		queue_item(CMD_RECORD, 8'h55);
		queue_item(CMD_RECORD, 8'hAA);
		queue_item(CMD_RECORD, 8'hFF);
		queue_item(CMD_RECORD, 8'hAA);
		queue_item(CMD_RECORD, 8'hAA);
		queue_item(CMD_DUMP,   8'h5A);
		queue_item(CMD_RECORD, 8'h00);
		queue_item(CMD_RECORD, 8'h55);
		queue_item(CMD_DUMP,   8'hA5);
		queue_item(CMD_DUMP,   8'h00);
		queue_item(CMD_RECORD, 8'h01);
		queue_item(CMD_RECORD, 8'h80);
		queue_item(CMD_RECORD, 8'h01);
		queue_item(CMD_DUMP,   8'h80);

		// random: mostly records, hits from a small hot set, misses from the full range
		for (int i = 0; i < 260; i++) begin
			if ($urandom_range(0, 99) < 12)
				queue_item(CMD_DUMP, 8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 99) < 60)
				queue_item(CMD_RECORD, 8'($urandom_range(0, 15)));
			else
				queue_item(CMD_RECORD, 8'($urandom_range(0, 255)));
		end

		// fill the table for sure, then records of new symbols get dropped
		for (int i = 0; i < 80; i++)
			queue_item(CMD_RECORD, 8'(i));
		queue_item(CMD_DUMP, 8'h00);
		for (int i = 0; i < 12; i++)
			queue_item(CMD_RECORD, 8'($urandom_range(0, 255)));
		queue_item(CMD_DUMP, 8'hFF);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || s_tvalid || due_rows.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("covered %0d records (%0d dropped on a full table, %0d held at max count)",
			n_records, n_dropped, n_sat_holds);
		$display("and %0d dumps (%0d of an empty table) yielding %0d checked rows",
			n_dumps, n_empty, n_rows);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
